@@ rtl/boxf3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package boxf3_pkg;

  // Configuration register widths and indexes
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_ADDR_W   = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

  localparam int MIN_SIDE = 3;

  // Input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Divide by nine: floor(s / 9) == (s * 3641) >> 15 for every 12-bit window sum
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 12'd3641;

  localparam int CHAN_W = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  typedef struct packed {
    logic              command;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_last;
  } out_word_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/boxf3_line_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two row buffers. Read both at one column, then on a later write shift the
// column down: upper takes the old lower word, lower takes the new pixel.
module boxf3_line_store #(
  parameter int DEPTH = 1024
) (
  input  wire                          clk_i,
  input  wire                          rd_en_i,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr_i,
  input  wire                          wr_en_i,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  boxf3_pkg::pix_t              wr_pix_i,
  output boxf3_pkg::pix_t              upper_o,
  output boxf3_pkg::pix_t              lower_o
);

  boxf3_pkg::pix_t upper_mem [DEPTH];
  boxf3_pkg::pix_t lower_mem [DEPTH];
  boxf3_pkg::pix_t upper_q;
  boxf3_pkg::pix_t lower_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      upper_q <= upper_mem[rd_addr_i];
      lower_q <= lower_mem[rd_addr_i];
    end
  end

  // Write back uses the held read word of the same column
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= lower_q;
      lower_mem[wr_addr_i] <= wr_pix_i;
    end
  end

  assign upper_o = upper_q;
  assign lower_o = lower_q;

endmodule

`default_nettype wire

@@ rtl/boxf3_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 3x3 window: three rows of three columns, newest column at the right.
module boxf3_window (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              shift_en_i,
  input  boxf3_pkg::pix_t  above2_i,
  input  boxf3_pkg::pix_t  above1_i,
  input  boxf3_pkg::pix_t  incoming_i,
  output boxf3_pkg::sum_t  sums_o,
  output boxf3_pkg::pix_t  center_o
);

  boxf3_pkg::pix_t win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_en_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= above2_i;
      win_q[5] <= above1_i;
      win_q[8] <= incoming_i;
    end
  end

  always_comb begin
    sums_o = '0;
    for (int i = 0; i < 9; i++) begin
      sums_o.red   = sums_o.red   + boxf3_pkg::SUM_W'(win_q[i].red);
      sums_o.green = sums_o.green + boxf3_pkg::SUM_W'(win_q[i].green);
      sums_o.blue  = sums_o.blue  + boxf3_pkg::SUM_W'(win_q[i].blue);
    end
  end

  assign center_o = win_q[4];

endmodule

`default_nettype wire

@@ rtl/boxf3_mean.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Output stage: divide each channel sum by nine, or pass the center on a border.
module boxf3_mean (
  input  wire                   clk_i,
  input  wire                   load_i,
  input  boxf3_pkg::sum_t       sums_i,
  input  boxf3_pkg::pix_t       center_i,
  input  boxf3_pkg::ctl_t       ctl_i,
  output boxf3_pkg::out_word_t  data_o
);

  localparam int ProdW = boxf3_pkg::SUM_W + boxf3_pkg::RECIP_W;

  logic [ProdW-1:0]           prod_r;
  logic [ProdW-1:0]           prod_g;
  logic [ProdW-1:0]           prod_b;
  boxf3_pkg::out_word_t       data_d;
  boxf3_pkg::out_word_t       data_q;

  always_comb begin
    prod_r = ProdW'(sums_i.red)   * ProdW'(boxf3_pkg::RECIP_NINE);
    prod_g = ProdW'(sums_i.green) * ProdW'(boxf3_pkg::RECIP_NINE);
    prod_b = ProdW'(sums_i.blue)  * ProdW'(boxf3_pkg::RECIP_NINE);
    if (ctl_i.border) begin
      data_d.red_out   = center_i.red;
      data_d.green_out = center_i.green;
      data_d.blue_out  = center_i.blue;
    end else begin
      data_d.red_out   = prod_r[boxf3_pkg::RECIP_SHIFT +: boxf3_pkg::CHAN_W];
      data_d.green_out = prod_g[boxf3_pkg::RECIP_SHIFT +: boxf3_pkg::CHAN_W];
      data_d.blue_out  = prod_b[boxf3_pkg::RECIP_SHIFT +: boxf3_pkg::CHAN_W];
    end
    data_d.frame_last = ctl_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ rtl/box_filter_3x3_rgb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// 3x3 mean filter on an RGB raster stream.
// Input channel: in_valid_i / in_ready_o with in_data_i. A word with command
// pixel carries one pixel in raster order; a flush word is dropped until the
// frame's last pixel is in, then every word (pixel or flush) drains one more
// position of the tail. Output channel: out_valid_o / out_ready_i with
// out_data_o; frame_last marks the final pixel of a frame, after which the
// next pixel starts a new frame. Border pixels are copied, interior pixels
// get floor(sum / 9) per channel.
// Throughput: one word per cycle unless the receiver stalls, set by the
// single read and single write port of each line store (one column read
// and written per word). Pipeline: the line store read at the accepting
// edge, then window shift, registered window sum, divide into the output
// register; results lag the pixel stream by one row plus one pixel.
// Reset clears the frame position, the window and the pipeline; width and
// height return to 640 x 480. Line stores are not cleared. A register write
// restarts the frame. When the receiver stalls, the pipeline fills behind the
// held output word and in_ready_o drops only once every stage is occupied.
module box_filter_3x3_rgb_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  boxf3_pkg::in_word_t                     in_data_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output boxf3_pkg::out_word_t                    out_data_o,
  input  wire                                     cfg_we_i,
  input  wire  [boxf3_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  wire  [boxf3_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CntW = ($clog2(MAX_WIDTH + 1) > boxf3_pkg::WIDTH_REG_W) ?
                        $clog2(MAX_WIDTH + 1) : boxf3_pkg::WIDTH_REG_W;
  // One extra bit: the row count runs one past the height while draining
  localparam int RowW = boxf3_pkg::HEIGHT_REG_W + 1;

  // Configuration
  logic [boxf3_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [boxf3_pkg::HEIGHT_REG_W-1:0] height_q;

  // Frame position
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [CntW-1:0] width_ext;
  logic [CntW-1:0] used_w;
  logic [CntW-1:0] w_m1;
  logic [RowW-1:0] height_ext;
  logic [RowW-1:0] used_h;
  logic [RowW-1:0] h_m1;
  logic [CntW-1:0] col_ext;
  logic [CntW-1:0] col_inc;
  logic [CntW-1:0] ocol;
  logic [RowW-1:0] orow;
  logic            col_nz;
  logic            draining;
  logic            step;
  boxf3_pkg::pix_t incoming;
  boxf3_pkg::ctl_t step_ctl;

  // Pipeline enables, from the output back
  logic en_a, en_b, en_c, en_d;
  logic b_load;

  // Stage A: line store read issued
  logic            a_v_q;
  boxf3_pkg::ctl_t a_ctl_q;
  boxf3_pkg::pix_t a_pix_q;
  logic [ColW-1:0] a_col_q;

  // Stage B: window holds the item's neighborhood
  logic            b_v_q;
  boxf3_pkg::ctl_t b_ctl_q;

  // Stage C: registered sums
  logic            c_v_q;
  boxf3_pkg::ctl_t c_ctl_q;
  boxf3_pkg::sum_t c_sums_q;
  boxf3_pkg::pix_t c_center_q;

  logic            out_v_q;

  boxf3_pkg::pix_t above2;
  boxf3_pkg::pix_t above1;
  boxf3_pkg::sum_t win_sums;
  boxf3_pkg::pix_t win_center;

  // Clamp the configured sizes
  always_comb begin
    width_ext = CntW'(width_q);
    if (width_ext < CntW'(boxf3_pkg::MIN_SIDE)) begin
      used_w = CntW'(boxf3_pkg::MIN_SIDE);
    end else if (width_ext > CntW'(MAX_WIDTH)) begin
      used_w = CntW'(MAX_WIDTH);
    end else begin
      used_w = width_ext;
    end
    height_ext = RowW'(height_q);
    if (height_ext < RowW'(boxf3_pkg::MIN_SIDE)) begin
      used_h = RowW'(boxf3_pkg::MIN_SIDE);
    end else begin
      used_h = height_ext;
    end
    w_m1 = used_w - CntW'(1);
    h_m1 = used_h - RowW'(1);
  end

  assign en_d       = !out_v_q || out_ready_i;
  assign en_c       = !c_v_q || en_d;
  assign en_b       = !b_v_q || en_c;
  assign en_a       = !a_v_q || en_b;
  assign in_ready_o = en_a;
  assign b_load     = a_v_q && en_b;

  // Decode the accepted word and the output position it produces
  always_comb begin
    draining = row_q >= used_h;
    step     = in_valid_i && in_ready_o &&
               (draining || (in_data_i.command == boxf3_pkg::CMD_PIXEL));
    if (draining) begin
      incoming = '0;
    end else begin
      incoming.red   = in_data_i.red_in;
      incoming.green = in_data_i.green_in;
      incoming.blue  = in_data_i.blue_in;
    end
    col_ext = CntW'(col_q);
    col_nz  = col_q != '0;
    if (col_nz) begin
      orow = row_q - RowW'(1);
      ocol = col_ext - CntW'(1);
    end else begin
      orow = row_q - RowW'(2);
      ocol = w_m1;
    end
    step_ctl.emit   = (row_q > RowW'(1)) || ((row_q == RowW'(1)) && col_nz);
    step_ctl.last   = (orow == h_m1) && (ocol == w_m1);
    step_ctl.border = (orow == '0) || (orow == h_m1) || (ocol == '0) || (ocol == w_m1);
    col_inc = col_ext + CntW'(1);

    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (step) begin
      if (step_ctl.emit && step_ctl.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= used_w) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= boxf3_pkg::WIDTH_RESET;
      height_q <= boxf3_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        boxf3_pkg::REG_WIDTH:  width_q  <= cfg_data_i[boxf3_pkg::WIDTH_REG_W-1:0];
        boxf3_pkg::REG_HEIGHT: height_q <= cfg_data_i[boxf3_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q   <= step;
      if (en_b) b_v_q   <= a_v_q;
      if (en_c) c_v_q   <= b_v_q && b_ctl_q.emit;
      if (en_d) out_v_q <= c_v_q;
    end
  end

  // Pipeline payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (step) begin
      a_ctl_q <= step_ctl;
      a_pix_q <= incoming;
      a_col_q <= col_q;
    end
    if (b_load) begin
      b_ctl_q <= a_ctl_q;
    end
    if (en_c && b_v_q) begin
      c_ctl_q    <= b_ctl_q;
      c_sums_q   <= win_sums;
      c_center_q <= win_center;
    end
  end

  boxf3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (step),
    .rd_addr_i (col_q),
    .wr_en_i   (b_load),
    .wr_addr_i (a_col_q),
    .wr_pix_i  (a_pix_q),
    .upper_o   (above2),
    .lower_o   (above1)
  );

  boxf3_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (b_load),
    .above2_i   (above2),
    .above1_i   (above1),
    .incoming_i (a_pix_q),
    .sums_o     (win_sums),
    .center_o   (win_center)
  );

  boxf3_mean u_mean (
    .clk_i    (clk_i),
    .load_i   (en_d && c_v_q),
    .sums_i   (c_sums_q),
    .center_i (c_center_q),
    .ctl_i    (c_ctl_q),
    .data_o   (out_data_o)
  );

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

@@ rtl/boxf3_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module boxf3_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_ready_o,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input boxf3_pkg::out_word_t out_data_o
);

  // Hold a stalled output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed while stalled");

  // Stall the input only behind a held output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled with output side free");

  // Empty pipeline after reset: no word can reach the output before passing every stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("output word appeared too soon after reset");

  // Ready out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_ready_o)
    else $error("input not ready after reset");

endmodule

bind box_filter_3x3_rgb_top boxf3_checker u_checker (.*);

`default_nettype wire

@@ tb/box_filter_3x3_rgb_checker.sv @@
`timescale 1ns / 1ps

module box_filter_3x3_rgb_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  input  wire                              in_ready_i,
  input  boxf3_pkg::in_word_t              in_data_i,
  input  wire                              out_valid_i,
  input  wire                              out_ready_i,
  input  boxf3_pkg::out_word_t             out_data_i,
  input  wire                              cfg_we_i,
  input  wire  [boxf3_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire  [boxf3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      results_o,
  output int unsigned                      frames_o
);

  import boxf3_pkg::*;

  localparam int TAPS         = 9;
  localparam int REPORT_LIMIT = 10;

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  // Rows two above and one above the incoming row, by column.
  pix_t        row_above2 [MAX_WIDTH];
  pix_t        row_above1 [MAX_WIDTH];
  // Three rows of three columns, oldest column first.
  pix_t        window [TAPS];
  int          col_pos;
  int          row_pos;

  out_word_t   expected_pixels [$];
  out_word_t   want;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned frames;

  function automatic int cols_used();
    int w;
    w = int'(width_reg);
    if (w < MIN_SIDE) w = MIN_SIDE;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int rows_used();
    int h;
    h = int'(height_reg);
    if (h < MIN_SIDE) h = MIN_SIDE;
    return h;
  endfunction

  // Advance the raster position by one word and queue the pixel it releases.
  function automatic void filter_word(in_word_t word);
    int          w, h, orow, ocol, i;
    int unsigned sum_r, sum_g, sum_b;
    pix_t        incoming, above2, above1;
    logic        emit, border, last;
    out_word_t   res;
    w = cols_used();
    h = rows_used();
    // Flush before the frame is complete: drop it.
    if (row_pos < h && word.command == CMD_FLUSH) return;
    incoming = '0;
    if (row_pos < h) begin
      incoming.red   = word.red_in;
      incoming.green = word.green_in;
      incoming.blue  = word.blue_in;
    end
    above2 = row_above2[col_pos];
    above1 = row_above1[col_pos];
    row_above2[col_pos] = above1;
    row_above1[col_pos] = incoming;
    for (i = 0; i < 3; i++) begin
      window[3*i]   = window[3*i+1];
      window[3*i+1] = window[3*i+2];
    end
    window[2] = above2;
    window[5] = above1;
    window[8] = incoming;

    emit = row_pos > 1 || (row_pos == 1 && col_pos >= 1);
    if (col_pos >= 1) begin
      orow = row_pos - 1;
      ocol = col_pos - 1;
    end else begin
      orow = row_pos - 2;
      ocol = w - 1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!emit) return;

    border = orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1;
    last   = orow == h - 1 && ocol == w - 1;
    if (border) begin
      res.red_out   = window[4].red;
      res.green_out = window[4].green;
      res.blue_out  = window[4].blue;
    end else begin
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (i = 0; i < TAPS; i++) begin
        sum_r += window[i].red;
        sum_g += window[i].green;
        sum_b += window[i].blue;
      end
      res.red_out   = 8'(sum_r / TAPS);
      res.green_out = 8'(sum_g / TAPS);
      res.blue_out  = 8'(sum_b / TAPS);
    end
    res.frame_last = last;
    expected_pixels.push_back(res);
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int c = 0; c < MAX_WIDTH; c++) begin
        row_above2[c] = '0;
        row_above1[c] = '0;
      end
      for (int t = 0; t < TAPS; t++) window[t] = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      checked    = 0;
      frames     = 0;
      expected_pixels.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      frames_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_WIDTH) begin
          width_reg = cfg_data_i[WIDTH_REG_W-1:0];
          col_pos   = 0;
          row_pos   = 0;
        end else if (cfg_addr_i == REG_HEIGHT) begin
          height_reg = cfg_data_i[HEIGHT_REG_W-1:0];
          col_pos    = 0;
          row_pos    = 0;
        end
      end
      // Check the outgoing word before predicting from this edge's input.
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (out_data_i.frame_last === 1'b1) frames++;
        if (expected_pixels.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected word r=%h g=%h b=%h last=%b", $time,
                     out_data_i.red_out, out_data_i.green_out, out_data_i.blue_out,
                     out_data_i.frame_last);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data_i.red_out !== want.red_out ||
              out_data_i.green_out !== want.green_out ||
              out_data_i.blue_out !== want.blue_out ||
              out_data_i.frame_last !== want.frame_last) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: word %0d expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                       $time, checked, want.red_out, want.green_out, want.blue_out,
                       want.frame_last, out_data_i.red_out, out_data_i.green_out,
                       out_data_i.blue_out, out_data_i.frame_last);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) filter_word(in_data_i);
      fail_count_o <= mismatches;
      pending_o    <= expected_pixels.size();
      results_o    <= checked;
      frames_o     <= frames;
    end
  end

endmodule

@@ tb/box_filter_3x3_rgb_top_tb.sv @@
`timescale 1ns / 1ps

module box_filter_3x3_rgb_top_tb;

  import boxf3_pkg::*;

  localparam int MAX_WIDTH       = 1024;
  localparam int RANDOM_WORDS    = 600;
  localparam int MAX_GAP         = 6;
  // Long receiver stall: far longer than the pipeline is deep.
  localparam int HOLD_OFF_CYCLES = 300;
  // Quiet cycles after the last expected word: lets words that release no pixel
  // leave the four-stage pipeline.
  localparam int SETTLE_CYCLES   = 16;
  // No word moved for this long means the block hung.
  localparam int STALL_LIMIT     = 2000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned frames;

  // Stimulus knobs; each has a single writer.
  logic        in_idle_en    = 1'b1;
  logic        out_idle_en   = 1'b1;
  logic        hold_off_req  = 1'b0;

  // Frame size the block currently uses, after clamping.
  int          frame_cols    = 640;
  int          frame_rows    = 480;
  int unsigned words_sent    = 0;
  int unsigned pixels_sent   = 0;
  int unsigned flushes_dropped = 0;
  int unsigned reg_writes    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  box_filter_3x3_rgb_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i)
  );

  box_filter_3x3_rgb_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .frames_o    (frames)
  );

  // Channel value biased toward the extremes so window sums reach their extremes often.
  function automatic logic [CHAN_W-1:0] pick_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_word(logic cmd);
    in_word_t word;
    word.command  = cmd;
    word.red_in   = pick_chan();
    word.green_in = pick_chan();
    word.blue_in  = pick_chan();
    return word;
  endfunction

  // Offer one word after a random gap; hold valid and payload until accepted.
  task automatic send_word(input in_word_t word);
    int unsigned gap;
    gap = in_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (word.command == CMD_PIXEL) pixels_sent++;
  endtask

  // Drop valid and wait until every expected pixel is out and the pipeline
  // has had time to empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Settle, then write width and/or height; each write restarts the frame.
  task automatic reconfigure(input bit set_w, input logic [CFG_DATA_W-1:0] w_val,
                             input bit set_h, input logic [CFG_DATA_W-1:0] h_val);
    settle();
    if (set_w) begin
      write_reg(REG_WIDTH, w_val);
      frame_cols = int'(w_val[WIDTH_REG_W-1:0]);
      if (frame_cols < MIN_SIDE) frame_cols = MIN_SIDE;
      if (frame_cols > MAX_WIDTH) frame_cols = MAX_WIDTH;
    end
    if (set_h) begin
      write_reg(REG_HEIGHT, h_val);
      frame_rows = int'(h_val[HEIGHT_REG_W-1:0]);
      if (frame_rows < MIN_SIDE) frame_rows = MIN_SIDE;
    end
    cfg_we_i <= 1'b0;
  endtask

  // Send the pixels of one frame, aborting after stop_at pixels if that comes
  // first. A complete frame is followed by its row-plus-one drain words, each
  // a flush or a pixel whose channels the block discards. With noisy set,
  // dropped flushes are sprinkled in before the last pixel.
  task automatic send_frame(input int stop_at, input bit noisy);
    int total, k;
    total = frame_cols * frame_rows;
    for (k = 0; k < total && k < stop_at; k++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        send_word(make_word(CMD_FLUSH));
        flushes_dropped++;
      end
      send_word(make_word(CMD_PIXEL));
    end
    if (stop_at >= total)
      for (k = 0; k <= frame_cols; k++)
        send_word(make_word($urandom_range(0, 1) ? CMD_PIXEL : CMD_FLUSH));
  endtask

  // Receiver: wait a random gap before each word, and once, on request,
  // stall for a long stretch so the block backs up into its input.
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = out_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_off_req && !held) begin
        gap += HOLD_OFF_CYCLES;
        held = 1'b1;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Watchdog: end the run if no word moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus.
  initial begin
    int          k, total, stop_at, nframes, f;
    int unsigned live_base;
    bit          set_w, set_h, noisy;
    logic [CFG_DATA_W-1:0] w_val, h_val;
    in_word_t    word;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size is 640 x 480: a short burst stays inside the first row and
    // releases nothing, then the next write cuts the frame short.
    live_base = 0;
    for (k = 0; k < 40; k++) send_word(make_word(CMD_PIXEL));

    // Smallest frame, reached through clamping: width 0 and height 2 both
    // act as 3. One interior pixel, whose window is the whole frame.
    reconfigure(1'b1, 12'd0, 1'b1, 12'd2);
    send_word(make_word(CMD_FLUSH));        // dropped: frame not yet complete
    flushes_dropped++;
    for (k = 0; k < 9; k++) begin
      word.command  = CMD_PIXEL;
      word.red_in   = 8'hFF;                // full-scale sum must stay 255
      word.green_in = 8'h00;
      word.blue_in  = CHAN_W'(k * 28 + 3);
      send_word(word);
    end
    // Drain the tail with both kinds of word; the pixel's channels are lost.
    send_word(make_word(CMD_FLUSH));
    send_word(make_word(CMD_PIXEL));
    send_word(make_word(CMD_FLUSH));
    send_word(make_word(CMD_PIXEL));        // carries frame_last
    send_word(make_word(CMD_FLUSH));        // dropped: new frame at its start
    flushes_dropped++;

    // Stall the receiver for a long stretch on a mid-size frame so the block
    // fills and backs up into its input.
    reconfigure(1'b1, 12'd8, 1'b1, 12'd6);
    hold_off_req <= 1'b1;
    send_frame(frame_cols * frame_rows, 1'b0);

    // Full rate on both sides; bit 11 of the width write is ignored, leaving
    // 0, which clamps to 3.
    reconfigure(1'b1, 12'h800, 1'b1, 12'd5);
    in_idle_en  <= 1'b0;
    out_idle_en <= 1'b0;
    send_frame(frame_cols * frame_rows, 1'b0);

    // Random phases: new size, then a few frames, some noisy, some cut short.
    live_base = words_sent - flushes_dropped;
    while (words_sent - flushes_dropped - live_base < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: begin set_w = 1'b1; set_h = 1'b0; end
        1: begin set_w = 1'b0; set_h = 1'b1; end
        default: begin set_w = 1'b1; set_h = 1'b1; end
      endcase
      case ($urandom_range(0, 7))
        0:       w_val = CFG_DATA_W'($urandom_range(0, 2));
        1:       w_val = CFG_DATA_W'($urandom_range(10, 40));
        2:       w_val = 12'h800 | CFG_DATA_W'($urandom_range(3, 8));
        default: w_val = CFG_DATA_W'($urandom_range(3, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       h_val = CFG_DATA_W'($urandom_range(0, 2));
        default: h_val = CFG_DATA_W'($urandom_range(3, 6));
      endcase
      reconfigure(set_w, w_val, set_h, h_val);
      // Stretches with no idling on either side now and then.
      in_idle_en  <= ($urandom_range(0, 3) != 0);
      out_idle_en <= ($urandom_range(0, 3) != 0);
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        total   = frame_cols * frame_rows;
        stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : total;
        noisy   = ($urandom_range(0, 2) == 0);
        send_frame(stop_at, noisy);
        // A cut frame stays open; the next phase's write restarts it.
        if (stop_at < total) break;
      end
    end

    settle();
    $display("Sent %0d words: %0d pixels, %0d dropped flushes, %0d register writes.",
             words_sent, pixels_sent, flushes_dropped, reg_writes);
    $display("Checked %0d filtered pixels over %0d whole frames, 3 to 40 wide, 3 to 6 tall.",
             results, frames);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
